### rtl/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned IndexW = 6;

  localparam logic [ByteW-1:0] HdrDollar = 8'h24;
  localparam logic [ByteW-1:0] HdrM      = 8'h4D;
  localparam logic [ByteW-1:0] HdrLt     = 8'h3C;

  localparam logic [SizeW-1:0] LimitReset = 7'd64;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DOLLAR = 3'd1,
    PH_M      = 3'd2,
    PH_ARROW  = 3'd3,
    PH_CMD    = 3'd4,
    PH_BODY   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    DR_IDLE = 2'd0,
    DR_READ = 2'd1,
    DR_LOAD = 2'd2,
    DR_HOLD = 2'd3
  } drain_e;

  typedef struct packed {
    logic [ByteW-1:0] command;
    logic [SizeW-1:0] size;
  } desc_t;

endpackage

### rtl/msp_frame_parser_core.sv
`timescale 1ns / 1ps

// Request-frame parser for '$' 'M' '<' size cmd payload checksum. Header, size
// and command words are taken one per cycle. Payload words go into a
// MAX_PAYLOAD-byte RAM; while a previous good frame is still draining, the
// parser stalls on payload and checksum words. A good frame is queued as a
// (command, size) descriptor and drained from the RAM: an idle state takes it,
// a read state reads the RAM, a load state puts the registered data in the
// output register, and a hold state shows it until taken, then goes back to
// read or idle; an empty frame goes from idle to hold with one result.
// payload_limit is written through the cfg port, which is always ready.
module msp_frame_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] command_o,
  output logic [6:0] payload_size_o,
  output logic [5:0] byte_index_o,
  output logic [7:0] payload_byte_o,
  output logic       has_payload_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_payload_limit_i
);
  import msp_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [SizeW-1:0] limit_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic             push, pop;
  desc_t            push_desc, head_desc;
  logic             fifo_empty, fifo_full;
  logic             back_busy;
  logic             drain_busy;

  assign cfg_ready_o = 1'b1;
  assign drain_busy  = !fifo_empty || back_busy || fifo_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_payload_limit_i;
    end
  end

  msp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .limit_i    (limit_q),
    .busy_i     (drain_busy),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  msp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  msp_desc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head_desc),
    .empty_o     (fifo_empty),
    .full_o      (fifo_full)
  );

  msp_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (fifo_empty),
    .head_i         (head_desc),
    .pop_o          (pop),
    .busy_o         (back_busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_o      (command_o),
    .payload_size_o (payload_size_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .has_payload_o  (has_payload_o),
    .last_o         (last_o)
  );

endmodule

### rtl/msp_ram.sv
`timescale 1ns / 1ps

module msp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/msp_desc_fifo.sv
`timescale 1ns / 1ps

module msp_desc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  msp_pkg::desc_t push_desc_i,
  input  logic           pop_i,
  output msp_pkg::desc_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import msp_pkg::*;

  desc_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

### rtl/msp_front.sv
`timescale 1ns / 1ps

module msp_front #(
  parameter int unsigned MAX_PAYLOAD = 64,
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  logic [6:0]     limit_i,
  input  logic           busy_i,
  output logic           wr_en_o,
  output logic [AW-1:0]  wr_addr_o,
  output logic [7:0]     wr_data_o,
  output logic           push_o,
  output msp_pkg::desc_t desc_o
);
  import msp_pkg::*;

  localparam logic [SizeW-1:0] MaxSize = SizeW'(MAX_PAYLOAD);

  phase_e             phase_q, phase_d;
  logic [SizeW-1:0]   size_q, size_d;
  logic [ByteW-1:0]   cmd_q, cmd_d;
  logic [ByteW-1:0]   xor_q, xor_d;
  logic [SizeW-1:0]   fill_q, fill_d;
  logic [SizeW-1:0]   eff_limit;
  logic               accept;
  logic               fill_open;

  assign eff_limit  = (limit_i > MaxSize) ? MaxSize : limit_i;
  // payload and checksum words wait while the previous frame drains
  assign in_stall_o = (phase_q == PH_BODY) && busy_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign fill_open  = (fill_q < size_q) && (fill_q < MaxSize);

  assign wr_addr_o = fill_q[AW-1:0];
  assign wr_data_o = rx_byte_i;
  assign desc_o    = '{command: cmd_q, size: size_q};

  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    cmd_d   = cmd_q;
    xor_d   = xor_q;
    fill_d  = fill_q;
    wr_en_o = 1'b0;
    push_o  = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_DOLLAR: begin
          phase_d = (rx_byte_i == HdrM) ? PH_M : PH_IDLE;
        end
        PH_M: begin
          phase_d = (rx_byte_i == HdrLt) ? PH_ARROW : PH_IDLE;
        end
        PH_ARROW: begin
          if (rx_byte_i > {1'b0, eff_limit}) begin
            phase_d = PH_IDLE;
          end else begin
            size_d  = rx_byte_i[SizeW-1:0];
            xor_d   = rx_byte_i;
            fill_d  = '0;
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PH_BODY;
        end
        PH_BODY: begin
          if (fill_open) begin
            xor_d   = xor_q ^ rx_byte_i;
            wr_en_o = 1'b1;
            fill_d  = fill_q + 7'd1;
          end else begin
            push_o  = (xor_q == rx_byte_i);
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = (rx_byte_i == HdrDollar) ? PH_DOLLAR : PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      size_q  <= '0;
      cmd_q   <= '0;
      xor_q   <= '0;
      fill_q  <= '0;
    end else begin
      phase_q <= phase_d;
      size_q  <= size_d;
      cmd_q   <= cmd_d;
      xor_q   <= xor_d;
      fill_q  <= fill_d;
    end
  end

endmodule

### rtl/msp_back.sv
`timescale 1ns / 1ps

module msp_back #(
  parameter int unsigned MAX_PAYLOAD = 64,
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  msp_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           busy_o,
  output logic           rd_en_o,
  output logic [AW-1:0]  rd_addr_o,
  input  logic [7:0]     rd_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     command_o,
  output logic [6:0]     payload_size_o,
  output logic [5:0]     byte_index_o,
  output logic [7:0]     payload_byte_o,
  output logic           has_payload_o,
  output logic           last_o
);
  import msp_pkg::*;

  drain_e            state_q, state_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [SizeW-1:0]  size_q, size_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic              has_q, has_d;
  logic              last_q, last_d;

  assign busy_o         = (state_q != DR_IDLE);
  assign out_valid_o    = (state_q == DR_HOLD);
  assign rd_addr_o      = idx_q[AW-1:0];
  assign command_o      = cmd_q;
  assign payload_size_o = size_q;
  assign byte_index_o   = idx_q;
  assign payload_byte_o = byte_q;
  assign has_payload_o  = has_q;
  assign last_o         = last_q;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    size_d  = size_q;
    idx_d   = idx_q;
    byte_d  = byte_q;
    has_d   = has_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    rd_en_o = 1'b0;
    unique case (state_q)
      DR_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = head_i.command;
          size_d = head_i.size;
          idx_d  = '0;
          if (head_i.size == '0) begin
            byte_d  = '0;
            has_d   = 1'b0;
            last_d  = 1'b1;
            state_d = DR_HOLD;
          end else begin
            state_d = DR_READ;
          end
        end
      end
      DR_READ: begin
        rd_en_o = 1'b1;
        state_d = DR_LOAD;
      end
      DR_LOAD: begin
        byte_d  = rd_data_i;
        has_d   = 1'b1;
        last_d  = ({1'b0, idx_q} + 7'd1) == size_q;
        state_d = DR_HOLD;
      end
      DR_HOLD: begin
        if (!out_stall_i) begin
          if (last_q) begin
            state_d = DR_IDLE;
          end else begin
            idx_d   = idx_q + 6'd1;
            state_d = DR_READ;
          end
        end
      end
      default: begin
        state_d = DR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    size_q <= size_d;
    idx_q  <= idx_d;
    byte_q <= byte_d;
    has_q  <= has_d;
    last_q <= last_d;
  end

endmodule

### sim/tb_msp_frame_parser_core.sv
`timescale 1ns / 1ps

module tb_msp_frame_parser_core;
  import msp_pkg::*;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [7:0] command;
    logic [6:0] size;
    logic [5:0] index;
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } frame_word_t;

  logic       clk_i               = 1'b0;
  logic       rst_ni              = 1'b0;
  logic       in_valid_i          = 1'b0;
  logic [7:0] rx_byte_i           = '0;
  logic       out_stall_i         = 1'b0;
  logic       cfg_valid_i         = 1'b0;
  logic [6:0] cfg_payload_limit_i = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] command_o;
  logic [6:0] payload_size_o;
  logic [5:0] byte_index_o;
  logic [7:0] payload_byte_o;
  logic       has_payload_o;
  logic       last_o;
  logic       cfg_ready_o;

  // parser image
  phase_e     parse_ph  = PH_IDLE;
  logic [6:0] cur_size  = '0;
  logic [7:0] cur_cmd   = '0;
  logic [7:0] cur_xor   = '0;
  logic [6:0] fill_cnt  = '0;
  logic [6:0] limit_reg = LimitReset;
  logic [7:0] body_mem [MaxPayload];

  frame_word_t frame_words_q [$];
  int unsigned fault_cnt   = 0;
  int unsigned rx_sent     = 0;
  bit          src_idle_en = 1'b0;
  bit          snk_idle_en = 1'b0;
  bit          snk_hold_req = 1'b0;

  msp_frame_parser_core #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .command_o          (command_o),
    .payload_size_o     (payload_size_o),
    .byte_index_o       (byte_index_o),
    .payload_byte_o     (payload_byte_o),
    .has_payload_o      (has_payload_o),
    .last_o             (last_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_payload_limit_i(cfg_payload_limit_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned eff_limit();
    return (limit_reg > MaxPayload) ? MaxPayload : int'(limit_reg);
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    frame_word_t w;
    case (parse_ph)
      PH_DOLLAR: parse_ph = (b == HdrM) ? PH_M : PH_IDLE;
      PH_M:      parse_ph = (b == HdrLt) ? PH_ARROW : PH_IDLE;
      PH_ARROW: begin
        if (int'(b) > eff_limit()) begin
          parse_ph = PH_IDLE;
        end else begin
          cur_size = b[6:0];
          cur_xor  = b;
          fill_cnt = '0;
          parse_ph = PH_CMD;
        end
      end
      PH_CMD: begin
        cur_cmd  = b;
        cur_xor  = cur_xor ^ b;
        parse_ph = PH_BODY;
      end
      PH_BODY: begin
        if (fill_cnt < cur_size) begin
          cur_xor = cur_xor ^ b;
          body_mem[fill_cnt[5:0]] = b;
          fill_cnt = fill_cnt + 7'd1;
        end else begin
          if (cur_xor == b) begin
            if (cur_size == 0) begin
              w = '{command: cur_cmd, size: '0, index: '0, data: '0,
                    has_data: 1'b0, last: 1'b1};
              frame_words_q.push_back(w);
            end else begin
              for (int unsigned i = 0; i < cur_size; i++) begin
                w = '{command: cur_cmd, size: cur_size, index: i[5:0],
                      data: body_mem[i], has_data: 1'b1,
                      last: (i + 1 == cur_size)};
                frame_words_q.push_back(w);
              end
            end
          end
          parse_ph = PH_IDLE;
        end
      end
      default: parse_ph = (b == HdrDollar) ? PH_DOLLAR : PH_IDLE;
    endcase
  endtask

  task automatic cmp_field(input string name, input int unsigned exp_v,
                           input int unsigned act_v);
    if (exp_v != act_v) begin
      fault_cnt++;
      if (fault_cnt <= 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // monitor: input words feed the parser image, output words are checked
  initial begin
    frame_word_t w;
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) parse_rx_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (frame_words_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 100)
            $display("%0t: unexpected word, expected none, actual cmd %0h idx %0d data %0h",
                     $time, command_o, byte_index_o, payload_byte_o);
        end else begin
          w = frame_words_q.pop_front();
          cmp_field("command", w.command, command_o);
          cmp_field("payload_size", w.size, payload_size_o);
          cmp_field("byte_index", w.index, byte_index_o);
          cmp_field("payload_byte", w.data, payload_byte_o);
          cmp_field("has_payload", w.has_data, has_payload_o);
          cmp_field("last", w.last, last_o);
        end
      end
    end
  end

  // receiver side stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (snk_hold_req) begin
        snk_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    rx_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] size,
                            input int unsigned body_len, input bit rand_body,
                            input logic [7:0] fill, input bit corrupt);
    logic [7:0] chk;
    logic [7:0] v;
    chk = size ^ cmd;
    send_byte(HdrDollar);
    send_byte(HdrM);
    send_byte(HdrLt);
    send_byte(size);
    send_byte(cmd);
    for (int unsigned i = 0; i < body_len; i++) begin
      v   = rand_body ? 8'($urandom_range(0, 255)) : fill;
      chk = chk ^ v;
      send_byte(v);
    end
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (frame_words_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [6:0] v);
    wait_drained();
    cfg_valid_i         <= 1'b1;
    cfg_payload_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_frame_basics();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    send_frame(8'h00, 8'd0, 0, 1'b0, 8'h00, 1'b0);
    send_frame(8'hFF, 8'd1, 1, 1'b0, 8'hFF, 1'b0);
    send_frame(8'h6C, 8'd2, 2, 1'b0, 8'h00, 1'b0);
    send_frame(8'h01, 8'd3, 3, 1'b1, 8'h00, 1'b1);
    send_frame(8'h80, 8'd0, 0, 1'b0, 8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_header_faults();
    // second '$' drops to idle and is not taken as a new start
    send_byte(HdrDollar);
    send_frame(8'h11, 8'd0, 0, 1'b0, 8'h00, 1'b0);
    send_byte(HdrDollar);
    send_byte(HdrM);
    send_frame(8'h22, 8'd1, 1, 1'b0, 8'h5A, 1'b0);
    send_byte(HdrM);
    send_byte(HdrLt);
    send_frame(8'h33, 8'd1, 1, 1'b0, 8'hA5, 1'b0);
    send_byte(HdrDollar);
    send_byte(HdrM);
    send_byte(8'hFF);
    send_frame(8'h44, 8'd2, 2, 1'b1, 8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_size_limits();
    src_idle_en = 1'b0;
    write_limit(7'd5);
    send_frame(8'h10, 8'd5, 5, 1'b1, 8'h00, 1'b0);
    send_frame(8'h11, 8'd6, 6, 1'b1, 8'h00, 1'b0);
    write_limit(7'd0);
    send_frame(8'h12, 8'd0, 0, 1'b0, 8'h00, 1'b0);
    send_frame(8'h13, 8'd1, 1, 1'b1, 8'h00, 1'b0);
    // limit above capacity acts as capacity
    write_limit(7'd127);
    send_frame(8'h14, 8'd64, 64, 1'b1, 8'h00, 1'b0);
    send_frame(8'h15, 8'd65, 2, 1'b1, 8'h00, 1'b0);
    write_limit(7'd64);
    send_frame(8'h16, 8'd255, 3, 1'b1, 8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_drain_backpressure();
    src_idle_en  = 1'b0;
    snk_idle_en  = 1'b0;
    snk_hold_req = 1'b1;
    send_frame(8'hA1, 8'd16, 16, 1'b1, 8'h00, 1'b0);
    send_frame(8'hA2, 8'd8, 8, 1'b1, 8'h00, 1'b0);
    send_frame(8'hA3, 8'd4, 4, 1'b1, 8'h00, 1'b0);
    send_frame(8'hA4, 8'd0, 0, 1'b0, 8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned budget;
    int unsigned pick;
    int unsigned lim;
    int unsigned sz;
    for (int unsigned ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_limit(7'($urandom_range(1, 63)));
        1:       write_limit(7'd64);
        2:       write_limit(7'd127);
        default: write_limit(7'($urandom_range(8, 127)));
      endcase
      src_idle_en = (ph == 0 || ph == 1);
      snk_idle_en = (ph == 0 || ph == 2);
      lim    = eff_limit();
      budget = rx_sent + 10;
      while (rx_sent < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 16) begin
          send_byte(HdrDollar);
          if ($urandom_range(0, 1)) send_byte(HdrM);
          if ($urandom_range(0, 1)) send_byte(HdrLt);
          send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 24) begin
          sz = $urandom_range(lim + 1, 255);
          send_frame(8'($urandom_range(0, 255)), 8'(sz), $urandom_range(0, 6),
                     1'b1, 8'h00, 1'b0);
        end else begin
          sz = ($urandom_range(0, 99) < 85) ? $urandom_range(0, (lim < 8) ? lim : 8)
                                            : $urandom_range(0, lim);
          send_frame(8'($urandom_range(0, 255)), 8'(sz), sz, 1'b1, 8'h00,
                     $urandom_range(0, 9) == 0);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);
    test_frame_basics();
    test_header_faults();
    test_size_limits();
    test_drain_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (fault_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
